[rtl/core/ffha_pkg.sv]
// Shared constants, codes, types and helper functions of the first-fit heap allocator.
// Depends on nothing; every other file of the block but ffha_ram imports it.
package ffha_pkg;

  // Heap geometry. ALIGN_BYTES must be a power of two.
  localparam int HEAP_BYTES      = 4096;
  localparam int ALIGN_BYTES     = 4;
  localparam int HEADER_BYTES    = 8;
  localparam int MIN_BLOCK_BYTES = 12;

  localparam int HEAP_END = ((HEAP_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int HDR      = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int MIN_DATA = ((MIN_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int SLOTS    = HEAP_END / ALIGN_BYTES + 1;
  localparam int ALIGN_SH = $clog2(ALIGN_BYTES);

  localparam int OFF_W  = $clog2(HEAP_END + 1);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int STEP_W = $clog2(SLOTS + 1);
  localparam int REQ_W  = 16;
  localparam int FIT_W  = REQ_W + 1;
  localparam int ACT_W  = 2;
  localparam int ST_W   = 2;
  localparam int DATA_W = 13;

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TRIM  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_REFUSE = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD    = 2'd2;

  // Datapath operations issued by the controller.
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE    = 5'd0;
  localparam op_t OP_INIT0   = 5'd1;
  localparam op_t OP_INIT1   = 5'd2;
  localparam op_t OP_LOAD    = 5'd3;
  localparam op_t OP_A_SETUP = 5'd4;
  localparam op_t OP_RD_PTR  = 5'd5;
  localparam op_t OP_A_ADV   = 5'd6;
  localparam op_t OP_A_FIT   = 5'd7;
  localparam op_t OP_LINK1   = 5'd8;
  localparam op_t OP_LINK2   = 5'd9;
  localparam op_t OP_MARK    = 5'd10;
  localparam op_t OP_RD_LF   = 5'd11;
  localparam op_t OP_W_ADV   = 5'd12;
  localparam op_t OP_F_CLR   = 5'd13;
  localparam op_t OP_F_N     = 5'd14;
  localparam op_t OP_F_MN    = 5'd15;
  localparam op_t OP_F_P     = 5'd16;
  localparam op_t OP_F_MP    = 5'd17;
  localparam op_t OP_T_SETUP = 5'd18;
  localparam op_t OP_T_N     = 5'd19;
  localparam op_t OP_T_FREE  = 5'd20;
  localparam op_t OP_T_SPLIT = 5'd21;
  localparam op_t OP_RES_BAD = 5'd22;

  // Conditions the controller branches on.
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             req_zero;
    logic             size_big;
    logic             off_bad;
    logic             scan_go;
    logic             fit_ok;
    logic             split_alloc;
    logic             ptr_is_lf;
    logic             walk_go;
    logic             q_used;
    logic             grow;
    logic             same;
    logic             merge_n;
    logic             merge_p;
    logic             split;
  } dp_flags_t;

  // Rounds a request up to the alignment and to at least the minimum block.
  function automatic logic [FIT_W-1:0] fit_size(input logic [REQ_W-1:0] r);
    logic [FIT_W-1:0] s;
    s = (FIT_W'(r) + FIT_W'(ALIGN_BYTES - 1)) & ~FIT_W'(ALIGN_BYTES - 1);
    return (s < FIT_W'(MIN_DATA)) ? FIT_W'(MIN_DATA) : s;
  endfunction

  // Header table entry of a header offset.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] o);
    return SLOT_W'(o >> ALIGN_SH);
  endfunction

endpackage

[rtl/core/ffha_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/ffha_dp.sv]
// Datapath of the heap allocator: working registers, header tables and result word.
// Depends on ffha_pkg and ffha_ram.
module ffha_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  ffha_pkg::op_t              op,
  input  logic [ffha_pkg::ACT_W-1:0] action,
  input  logic [ffha_pkg::REQ_W-1:0] request_bytes,
  input  logic [ffha_pkg::REQ_W-1:0] block_offset,
  output ffha_pkg::dp_flags_t        flags,
  output logic [ffha_pkg::ST_W-1:0]  status,
  output logic [ffha_pkg::DATA_W-1:0] data_offset
);
  import ffha_pkg::*;

  logic [ACT_W-1:0]  act;
  logic [REQ_W-1:0]  req;
  logic [REQ_W-1:0]  off;
  logic [OFF_W-1:0]  size, ptr, nx, tm, nh, lf, lf_next;
  logic [STEP_W-1:0] steps;
  logic              split;
  logic [ST_W-1:0]   st;
  logic [DATA_W-1:0] res;

  logic              n_we, p_we, u_we, re;
  logic [SLOT_W-1:0] n_wa, p_wa, u_wa, raddr;
  logic [OFF_W-1:0]  n_wd, p_wd, q_next, q_prev;
  logic              u_wd, q_used;

  logic [FIT_W-1:0]  fit_req;
  logic [OFF_W:0]    ptr_hdr, rem, tsize, size_ext;
  logic [OFF_W+1:0]  split_need;
  logic              n_ge;
  logic [OFF_W-1:0]  hdr_of_off, nh_calc;
  logic [REQ_W-1:0]  off_sub;

  ffha_ram #(.WIDTH(OFF_W), .DEPTH(SLOTS)) u_next (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .re(re), .raddr(raddr), .rdata(q_next)
  );
  ffha_ram #(.WIDTH(OFF_W), .DEPTH(SLOTS)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .re(re), .raddr(raddr), .rdata(q_prev)
  );
  ffha_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used (
    .clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .re(re), .raddr(raddr), .rdata(q_used)
  );

  assign fit_req    = fit_size(req);
  assign ptr_hdr    = {1'b0, ptr} + (OFF_W+1)'(HDR);
  assign rem        = {1'b0, q_next} - ptr_hdr;
  assign n_ge       = {1'b0, q_next} >= ptr_hdr;
  assign tsize      = n_ge ? rem : '0;
  assign size_ext   = {1'b0, size};
  assign split_need = {1'b0, size_ext} + (OFF_W+2)'(HDR + MIN_DATA);
  assign off_sub    = off - REQ_W'(HDR);
  assign hdr_of_off = OFF_W'(off_sub);
  assign nh_calc    = OFF_W'(ptr_hdr + size_ext);

  always_comb begin
    flags.act         = act;
    flags.req_zero    = (req == '0);
    flags.size_big    = fit_req > FIT_W'(HEAP_END);
    flags.off_bad     = (off < REQ_W'(HDR)) || ({1'b0, off} >= FIT_W'(HEAP_END)) ||
                        ((off_sub & REQ_W'(ALIGN_BYTES - 1)) != '0);
    flags.scan_go     = (steps < STEP_W'(SLOTS)) && (ptr < OFF_W'(HEAP_END) - size);
    flags.fit_ok      = !q_used && n_ge && (rem >= size_ext);
    flags.split_alloc = {1'b0, rem} >= split_need;
    flags.ptr_is_lf   = (ptr == lf);
    flags.walk_go     = (steps < STEP_W'(SLOTS)) && (lf != OFF_W'(HEAP_END));
    flags.q_used      = q_used;
    flags.grow        = size_ext > tsize;
    flags.same        = size_ext == tsize;
    flags.merge_n     = (nx != ptr) && !q_used && (nx != OFF_W'(HEAP_END));
    flags.merge_p     = (tm != ptr) && !q_used;
    flags.split       = split;
  end

  // Table writes, read issue and the lowest-free pointer.
  always_comb begin
    n_we = 1'b0; n_wa = '0; n_wd = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0;
    u_we = 1'b0; u_wa = '0; u_wd = 1'b0;
    re = 1'b0; raddr = '0;
    lf_next = lf;
    case (op)
      OP_INIT0: begin
        n_we = 1'b1; n_wa = '0; n_wd = OFF_W'(HEAP_END);
        p_we = 1'b1; p_wa = '0; p_wd = '0;
        u_we = 1'b1; u_wa = '0; u_wd = 1'b0;
      end
      OP_INIT1: begin
        n_we = 1'b1; n_wa = SLOT_W'(SLOTS - 1); n_wd = OFF_W'(HEAP_END);
        p_we = 1'b1; p_wa = SLOT_W'(SLOTS - 1); p_wd = OFF_W'(HEAP_END);
        u_we = 1'b1; u_wa = SLOT_W'(SLOTS - 1); u_wd = 1'b1;
      end
      OP_RD_PTR: begin
        re = 1'b1; raddr = slot_of(ptr);
      end
      OP_LINK1: begin
        u_we = 1'b1; u_wa = slot_of(nh); u_wd = 1'b0;
        n_we = 1'b1; n_wa = slot_of(nh); n_wd = tm;
        p_we = 1'b1; p_wa = slot_of(nh); p_wd = ptr;
      end
      OP_LINK2: begin
        n_we = 1'b1; n_wa = slot_of(ptr); n_wd = nh;
        p_we = (tm != OFF_W'(HEAP_END)); p_wa = slot_of(tm); p_wd = nh;
      end
      OP_MARK: begin
        u_we = 1'b1; u_wa = slot_of(ptr); u_wd = 1'b1;
      end
      OP_RD_LF: begin
        re = 1'b1; raddr = slot_of(lf);
      end
      OP_W_ADV: lf_next = q_next;
      OP_F_CLR: begin
        u_we = 1'b1; u_wa = slot_of(hdr_of_off); u_wd = 1'b0;
        if (hdr_of_off < lf) lf_next = hdr_of_off;
      end
      OP_F_N: begin
        re = 1'b1; raddr = slot_of(q_next);
      end
      OP_F_MN: begin
        if (lf == nx) lf_next = ptr;
        n_we = 1'b1; n_wa = slot_of(ptr); n_wd = q_next;
        p_we = 1'b1; p_wa = slot_of(q_next); p_wd = ptr;
      end
      OP_F_P: begin
        re = 1'b1; raddr = slot_of(q_prev);
      end
      OP_F_MP: begin
        if (lf == ptr) lf_next = tm;
        n_we = 1'b1; n_wa = slot_of(tm); n_wd = nh;
        p_we = 1'b1; p_wa = slot_of(nh); p_wd = tm;
      end
      OP_T_N: begin
        re = 1'b1; raddr = slot_of(q_next);
      end
      OP_T_FREE: begin
        if (lf == nx) lf_next = nh;
      end
      OP_T_SPLIT: begin
        if (nh < lf) lf_next = nh;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lf <= '0;
    end else begin
      lf <= lf_next;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        act <= action;
        req <= request_bytes;
        off <= block_offset;
        st  <= ST_REFUSE;
        res <= '0;
      end
      OP_A_SETUP: begin
        size  <= OFF_W'(fit_req);
        ptr   <= lf;
        steps <= '0;
      end
      OP_A_ADV: begin
        ptr   <= q_next;
        steps <= steps + STEP_W'(1);
      end
      OP_A_FIT: begin
        nh  <= nh_calc;
        tm  <= q_next;
        st  <= ST_OK;
        res <= DATA_W'(ptr_hdr);
      end
      OP_MARK:  steps <= '0;
      OP_W_ADV: steps <= steps + STEP_W'(1);
      OP_F_CLR: begin
        ptr <= hdr_of_off;
        st  <= ST_OK;
      end
      OP_F_N: nx <= q_next;
      OP_F_P: begin
        tm <= q_prev;
        nh <= q_next;
      end
      OP_T_SETUP: begin
        ptr  <= hdr_of_off;
        size <= OFF_W'(fit_req);
      end
      OP_T_N: begin
        nx    <= q_next;
        nh    <= nh_calc;
        split <= {1'b0, tsize} >= split_need;
        if (size_ext <= tsize) begin
          st  <= ST_OK;
          res <= DATA_W'(off);
        end
      end
      OP_T_FREE:  tm <= q_next;
      OP_T_SPLIT: tm <= nx;
      OP_RES_BAD: begin
        st  <= ST_BAD;
        res <= (act == ACT_TRIM) ? DATA_W'(off) : '0;
      end
      default: ;
    endcase
  end

  assign status      = st;
  assign data_offset = res;

endmodule

[rtl/core/ffha_ctrl.sv]
// Controller state machine of the heap allocator: sequences datapath operations.
// Depends on ffha_pkg.
module ffha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ffha_pkg::ACT_W-1:0] action,
  input  ffha_pkg::dp_flags_t flags,
  output ffha_pkg::op_t       op,
  output logic                busy,
  output logic                valid
);
  import ffha_pkg::*;

  localparam logic [4:0] S_INIT0   = 5'd0;
  localparam logic [4:0] S_INIT1   = 5'd1;
  localparam logic [4:0] S_IDLE    = 5'd2;
  localparam logic [4:0] S_A_START = 5'd3;
  localparam logic [4:0] S_A_LOOP  = 5'd4;
  localparam logic [4:0] S_A_CHK   = 5'd5;
  localparam logic [4:0] S_LINK1   = 5'd6;
  localparam logic [4:0] S_LINK2   = 5'd7;
  localparam logic [4:0] S_A_MARK  = 5'd8;
  localparam logic [4:0] S_W_ISS   = 5'd9;
  localparam logic [4:0] S_W_CHK   = 5'd10;
  localparam logic [4:0] S_F_CLR   = 5'd11;
  localparam logic [4:0] S_F_RD    = 5'd12;
  localparam logic [4:0] S_F_N     = 5'd13;
  localparam logic [4:0] S_F_MN    = 5'd14;
  localparam logic [4:0] S_F_RDP   = 5'd15;
  localparam logic [4:0] S_F_P     = 5'd16;
  localparam logic [4:0] S_F_MP    = 5'd17;
  localparam logic [4:0] S_T_START = 5'd18;
  localparam logic [4:0] S_T_RD    = 5'd19;
  localparam logic [4:0] S_T_N     = 5'd20;
  localparam logic [4:0] S_T_ACT   = 5'd21;
  localparam logic [4:0] S_DONE    = 5'd22;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    op = OP_NONE;
    state_next = state;
    case (state)
      S_INIT0: begin
        op = OP_INIT0;
        state_next = S_INIT1;
      end
      S_INIT1: begin
        op = OP_INIT1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op = OP_LOAD;
          case (action)
            ACT_ALLOC: state_next = S_A_START;
            ACT_FREE:  state_next = S_F_CLR;
            ACT_TRIM:  state_next = S_T_START;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_A_START: begin
        if (flags.req_zero || flags.size_big) begin
          state_next = S_DONE;
        end else begin
          op = OP_A_SETUP;
          state_next = S_A_LOOP;
        end
      end
      S_A_LOOP: begin
        if (flags.scan_go) begin
          op = OP_RD_PTR;
          state_next = S_A_CHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_A_CHK: begin
        if (flags.fit_ok) begin
          op = OP_A_FIT;
          state_next = flags.split_alloc ? S_LINK1 : S_A_MARK;
        end else begin
          op = OP_A_ADV;
          state_next = S_A_LOOP;
        end
      end
      S_LINK1: begin
        op = OP_LINK1;
        state_next = S_LINK2;
      end
      S_LINK2: begin
        op = OP_LINK2;
        state_next = (flags.act == ACT_ALLOC) ? S_A_MARK : S_DONE;
      end
      S_A_MARK: begin
        op = OP_MARK;
        state_next = flags.ptr_is_lf ? S_W_ISS : S_DONE;
      end
      S_W_ISS: begin
        if (flags.walk_go) begin
          op = OP_RD_LF;
          state_next = S_W_CHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_W_CHK: begin
        if (flags.q_used) begin
          op = OP_W_ADV;
          state_next = S_W_ISS;
        end else begin
          state_next = S_DONE;
        end
      end
      S_F_CLR: begin
        if (flags.off_bad) begin
          op = OP_RES_BAD;
          state_next = S_DONE;
        end else begin
          op = OP_F_CLR;
          state_next = S_F_RD;
        end
      end
      S_F_RD: begin
        op = OP_RD_PTR;
        state_next = S_F_N;
      end
      S_F_N: begin
        op = OP_F_N;
        state_next = S_F_MN;
      end
      S_F_MN: begin
        if (flags.merge_n) op = OP_F_MN;
        state_next = S_F_RDP;
      end
      S_F_RDP: begin
        op = OP_RD_PTR;
        state_next = S_F_P;
      end
      S_F_P: begin
        op = OP_F_P;
        state_next = S_F_MP;
      end
      S_F_MP: begin
        if (flags.merge_p) op = OP_F_MP;
        state_next = S_DONE;
      end
      S_T_START: begin
        if (flags.size_big) begin
          state_next = S_DONE;
        end else if (flags.off_bad) begin
          op = OP_RES_BAD;
          state_next = S_DONE;
        end else begin
          op = OP_T_SETUP;
          state_next = S_T_RD;
        end
      end
      S_T_RD: begin
        op = OP_RD_PTR;
        state_next = S_T_N;
      end
      S_T_N: begin
        op = OP_T_N;
        state_next = (flags.grow || flags.same) ? S_DONE : S_T_ACT;
      end
      S_T_ACT: begin
        if (!flags.q_used) begin
          op = OP_T_FREE;
          state_next = S_LINK1;
        end else if (flags.split) begin
          op = OP_T_SPLIT;
          state_next = S_LINK1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy  = (state != S_IDLE);
  assign valid = (state == S_DONE);

endmodule

[rtl/core/first_fit_heap_allocator_unit.sv]
// Top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp (which holds the ffha_ram header tables).
//
// A request word (action, request_bytes, block_offset) is taken when start is high
// and busy is low. Exactly one result word follows: valid is high for one cycle with
// status and data_offset, and the receiver must take it then, since the block cannot
// hold a result. After reset the block writes the start and end headers, with busy
// high. Work is set by the header tables, held in RAMs with one write and one
// registered read port, so each header read is issued in one state and used later.
// A free clears the used bit and merges the block with a free next neighbour, then
// with a free previous one. A shrinking trim merges the tail into a free next block
// or splits it off. An allocate runs the first-fit scan, splits the block when it is
// large enough and, on taking the lowest free block, advances the lowest-free pointer.
// Requests refused or rejected on their request word alone never read the tables.
module first_fit_heap_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ffha_pkg::ACT_W-1:0]  action,
  input  logic [ffha_pkg::REQ_W-1:0]  request_bytes,
  input  logic [ffha_pkg::REQ_W-1:0]  block_offset,
  output logic                        valid,
  output logic [ffha_pkg::ST_W-1:0]   status,
  output logic [ffha_pkg::DATA_W-1:0] data_offset
);
  import ffha_pkg::*;

  // Operation of the current cycle and the conditions that steer the sequence.
  op_t       op;
  dp_flags_t flags;

  // The controller owns the handshake: it takes a request only in its idle state
  // and raises valid in a result state of its own.
  ffha_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .flags(flags), .op(op), .busy(busy), .valid(valid)
  );

  // The datapath captures the request word on the load operation and keeps the
  // result word stable until the next request is loaded.
  ffha_dp u_dp (
    .clk(clk), .rst(rst), .op(op),
    .action(action), .request_bytes(request_bytes), .block_offset(block_offset),
    .flags(flags), .status(status), .data_offset(data_offset)
  );

endmodule

[rtl/core/ffha_checker.sv]
// Port-level checks of the heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_unit.
module ffha_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        valid,
  input logic [ffha_pkg::ST_W-1:0]   status,
  input logic [ffha_pkg::DATA_W-1:0] data_offset
);
  import ffha_pkg::*;

  // An accepted request raises busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted request did not raise busy");

  // A result word lasts one cycle and the block is idle after it.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid && !busy) else $error("result word not followed by idle");

  // No request is taken while a result is shown.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> busy) else $error("result shown while not busy");

  // Refusals carry a zero offset and no unused status code appears.
  a_refuse_zero: assert property (@(posedge clk) disable iff (rst)
    valid |-> (status == ST_OK || status == ST_BAD ||
               (status == ST_REFUSE && data_offset == '0)))
    else $error("bad status or nonzero offset on refusal");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .valid(valid),
  .status(status), .data_offset(data_offset)
);
